@@ sv/string_literal_escape_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// string literal escape decoder: assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH
`define STRING_LITERAL_ESCAPE_DECODER_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define SLED_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define SLED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define SLED_ASSERT_NEXT_RAW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sled_pkg.sv @@
// ----------------------------------------------------------------------------
// sled_pkg
// result codes and the types passed between front, queue and back
// ----------------------------------------------------------------------------
package sled_pkg;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_EOF     = 3'd1;
    localparam logic [2:0] ERR_NEWLINE = 3'd2;
    localparam logic [2:0] ERR_ESCAPE  = 3'd3;
    localparam logic [2:0] ERR_HEX     = 3'd4;
    localparam logic [2:0] ERR_DEC     = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
    } t_result;

    // one or two results caused by one input byte
    typedef struct packed {
        t_result r0;
        t_result r1;
        logic    two;
    } t_bundle;

endpackage

@@ sv/string_literal_escape_decoder.sv @@
// ----------------------------------------------------------------------------
// string_literal_escape_decoder
// decodes escapes of a delimited string literal, one source byte per cycle
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  source    in         push / full         i_data_byte, i_end_of_input
//  result    out        empty / pop         o_kind, o_out_byte, o_error_code, o_last
//
//  a source byte is taken every cycle while the result queue has room; the
//  decode state machine in the front settles each byte in the cycle it is taken
//  a result leaves every cycle that pop is high while the queue is not empty;
//  a byte that ends a short decimal escape gives two results unless it is a backslash
//  full rises only when QUEUE_DEPTH bundles are waiting, so a stalled reader
//  backs up into the source side after that many bundles
//  synchronous active-low reset returns to idle and empties the queue
// ----------------------------------------------------------------------------
module string_literal_escape_decoder
    import sled_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // source side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_error_code,
    output logic       o_last
);

    // source transaction taken this edge
    logic    accept;
    // front produced at least one result for this byte
    logic    front_valid;
    t_bundle front_bundle;
    // queue head towards the back
    t_bundle head;
    logic    head_valid;
    logic    deq;

    assign accept = push && !full;

    // front: state machine that classifies and decodes the byte
    sled_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (front_valid),
        .o_bundle       (front_bundle)
    );

    // bytes with no result (opening delimiter, backslash, non-final escape digits) are not queued
    sled_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (accept && front_valid),
        .i_wr_data  (front_bundle),
        .i_rd       (deq),
        .o_head     (head),
        .o_nonempty (head_valid),
        .o_full     (full)
    );

    // back: splits a two-result bundle into two result transactions
    sled_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_nonempty   (head_valid),
        .i_pop        (pop),
        .o_deq        (deq),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_out_byte   (o_out_byte),
        .o_error_code (o_error_code),
        .o_last       (o_last)
    );

endmodule

@@ sv/sled_front.sv @@
// ----------------------------------------------------------------------------
// sled_front
// per-byte decode state machine, one byte per cycle while i_accept is high, bundles its results
// ----------------------------------------------------------------------------
module sled_front
    import sled_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    output t_bundle    o_bundle
);

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_STR  = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_HEX  = 3'd3;
    localparam logic [2:0] MODE_DEC  = 3'd4;
    localparam logic [2:0] MODE_NL   = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_X     = 8'h78;

    typedef struct packed {
        logic       valid;
        t_result    res;
        logic [2:0] mode;
    } t_step;

    function automatic t_result mk(input logic [1:0] k, input logic [7:0] b,
                                   input logic [2:0] e);
        t_result r;
        r.kind       = k;
        r.out_byte   = b;
        r.error_code = e;
        return r;
    endfunction

    function automatic t_step string_byte(input logic [7:0] c, input logic [7:0] delim);
        t_step s;
        s.valid = 1'b1;
        s.res   = mk(KIND_BYTE, c, ERR_NONE);
        s.mode  = MODE_STR;
        priority if (c == delim) begin
            s.res  = mk(KIND_END, 8'd0, ERR_NONE);
            s.mode = MODE_IDLE;
        end else if (c == CH_NUL) begin
            s.res  = mk(KIND_ERR, 8'd0, ERR_EOF);
            s.mode = MODE_IDLE;
        end else if (c == CH_LF || c == CH_CR) begin
            s.res  = mk(KIND_ERR, 8'd0, ERR_NEWLINE);
            s.mode = MODE_IDLE;
        end else if (c == CH_BSL) begin
            s.valid = 1'b0;
            s.mode  = MODE_ESC;
        end else begin
            s.valid = 1'b1;
        end
        return s;
    endfunction

    logic [7:0] c;
    logic       c_dec;
    logic [3:0] c_dval;
    logic       c_hex;
    logic [3:0] c_hval;
    logic [13:0] dec_acc;

    logic [2:0] r_mode,  n_mode;
    logic [7:0] r_delim, n_delim;
    logic [9:0] r_val,   n_val;
    logic [1:0] r_cnt,   n_cnt;
    logic       r_cr,    n_cr;

    t_step      sb;
    logic       v0, v1;
    t_result    res0, res1;

    assign c      = i_end_of_input ? CH_NUL : i_data_byte;
    assign c_dec  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign c_dval = c[3:0];

    always_comb begin
        c_hex  = 1'b1;
        c_hval = c[3:0];
        priority if (c_dec) begin
            c_hval = c[3:0];
        end else if ((c >= CH_A && c <= CH_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
            c_hval = c[3:0] + 4'd9;
        end else begin
            c_hex = 1'b0;
        end
    end

    // value * 10 + digit as shifts and adds
    assign dec_acc = {1'b0, r_val, 3'b000} + {3'b000, r_val, 1'b0} + {10'd0, c_dval};

    always_comb begin
        n_mode  = r_mode;
        n_delim = r_delim;
        n_val   = r_val;
        n_cnt   = r_cnt;
        n_cr    = r_cr;
        v0      = 1'b0;
        v1      = 1'b0;
        res0    = mk(KIND_BYTE, 8'd0, ERR_NONE);
        res1    = mk(KIND_BYTE, 8'd0, ERR_NONE);
        sb      = string_byte(c, r_delim);
        unique case (r_mode)
            MODE_STR: begin
                v0     = sb.valid;
                res0   = sb.res;
                n_mode = sb.mode;
            end
            MODE_ESC: begin
                n_mode = MODE_STR;
                v0     = 1'b1;
                unique case (c)
                    CH_A: res0 = mk(KIND_BYTE, 8'd7, ERR_NONE);
                    CH_B: res0 = mk(KIND_BYTE, 8'd8, ERR_NONE);
                    CH_F: res0 = mk(KIND_BYTE, 8'd12, ERR_NONE);
                    CH_N: res0 = mk(KIND_BYTE, 8'd10, ERR_NONE);
                    CH_R: res0 = mk(KIND_BYTE, 8'd13, ERR_NONE);
                    CH_T: res0 = mk(KIND_BYTE, 8'd9, ERR_NONE);
                    CH_V: res0 = mk(KIND_BYTE, 8'd11, ERR_NONE);
                    CH_BSL, CH_DQ, CH_SQ: res0 = mk(KIND_BYTE, c, ERR_NONE);
                    CH_X: begin
                        v0     = 1'b0;
                        n_mode = MODE_HEX;
                        n_val  = 10'd0;
                        n_cnt  = 2'd0;
                    end
                    CH_LF, CH_CR: begin
                        res0   = mk(KIND_BYTE, CH_LF, ERR_NONE);
                        n_cr   = (c == CH_CR);
                        n_mode = MODE_NL;
                    end
                    CH_NUL: begin
                        res0   = mk(KIND_ERR, 8'd0, ERR_EOF);
                        n_mode = MODE_IDLE;
                    end
                    default: begin
                        if (c_dec) begin
                            v0     = 1'b0;
                            n_mode = MODE_DEC;
                            n_val  = {6'd0, c_dval};
                            n_cnt  = 2'd1;
                        end else begin
                            res0   = mk(KIND_ERR, 8'd0, ERR_ESCAPE);
                            n_mode = MODE_IDLE;
                        end
                    end
                endcase
            end
            MODE_HEX: begin
                if (!c_hex) begin
                    v0     = 1'b1;
                    res0   = mk(KIND_ERR, 8'd0, ERR_HEX);
                    n_mode = MODE_IDLE;
                end else begin
                    n_val = {2'b00, r_val[3:0], c_hval};
                    n_cnt = r_cnt + 2'd1;
                    if (n_cnt >= 2'd2) begin
                        v0     = 1'b1;
                        res0   = mk(KIND_BYTE, n_val[7:0], ERR_NONE);
                        n_mode = MODE_STR;
                    end
                end
            end
            MODE_DEC: begin
                if (c_dec) begin
                    n_val = dec_acc[9:0];
                    n_cnt = r_cnt + 2'd1;
                    if (n_cnt == 2'd3 || n_cnt == 2'd0) begin
                        v0 = 1'b1;
                        if (n_val > 10'd255) begin
                            res0   = mk(KIND_ERR, 8'd0, ERR_DEC);
                            n_mode = MODE_IDLE;
                        end else begin
                            res0   = mk(KIND_BYTE, n_val[7:0], ERR_NONE);
                            n_mode = MODE_STR;
                        end
                    end
                end else begin
                    // value first, then the ending byte as a string byte
                    v0     = 1'b1;
                    res0   = mk(KIND_BYTE, r_val[7:0], ERR_NONE);
                    v1     = sb.valid;
                    res1   = sb.res;
                    n_mode = sb.mode;
                end
            end
            MODE_NL: begin
                n_mode = MODE_STR;
                if (!((r_cr && c == CH_LF) || (!r_cr && c == CH_CR))) begin
                    v0     = sb.valid;
                    res0   = sb.res;
                    n_mode = sb.mode;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (c != CH_NUL) begin
                    n_delim = c;
                    n_mode  = MODE_STR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_delim <= 8'd0;
            r_val   <= 10'd0;
            r_cnt   <= 2'd0;
            r_cr    <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_delim <= n_delim;
            r_val   <= n_val;
            r_cnt   <= n_cnt;
            r_cr    <= n_cr;
        end
    end

    assign o_valid     = v0;
    assign o_bundle.r0 = res0;
    assign o_bundle.r1 = res1;
    assign o_bundle.two = v1;

endmodule

@@ sv/sled_queue.sv @@
// ----------------------------------------------------------------------------
// sled_queue
// small register queue of result bundles between front and back
// ----------------------------------------------------------------------------
module sled_queue
    import sled_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_bundle i_wr_data,
    input  logic    i_rd,
    output t_bundle o_head,
    output logic    o_nonempty,
    output logic    o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_bundle       r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt,    n_cnt;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        unique case ({i_wr, i_rd})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_head     = r_mem[r_rd_ptr];
    assign o_nonempty = (r_cnt != '0);
    assign o_full     = (r_cnt == FULL_CNT);

endmodule

@@ sv/sled_back.sv @@
// ----------------------------------------------------------------------------
// sled_back
// hands out the results of the head bundle one transaction at a time
// ----------------------------------------------------------------------------
module sled_back
    import sled_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_bundle    i_head,
    input  logic       i_nonempty,
    input  logic       i_pop,
    output logic       o_deq,
    output logic       o_empty,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_error_code,
    output logic       o_last
);

    logic    r_second;
    logic    take;
    t_result cur;

    assign take  = i_pop && i_nonempty;
    assign o_deq = take && (r_second || !i_head.two);
    assign cur   = r_second ? i_head.r1 : i_head.r0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= !o_deq;
        end
    end

    assign o_empty      = !i_nonempty;
    assign o_kind       = cur.kind;
    assign o_out_byte   = cur.out_byte;
    assign o_error_code = cur.error_code;
    assign o_last       = r_second || !i_head.two;

endmodule

@@ sv/sled_checker.sv @@
// ----------------------------------------------------------------------------
// sled_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "string_literal_escape_decoder_defines.svh"

module sled_checker
    import sled_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_kind,
    input logic [7:0] o_out_byte,
    input logic [2:0] o_error_code,
    input logic       o_last
);

    `SLED_ASSERT_NEXT_RAW(a_reset_empty, i_clk, !i_rst_n, empty, "queue not empty after reset")

    `SLED_ASSERT_IMPLY(a_end_err_last, i_clk, i_rst_n, !empty && o_kind != KIND_BYTE, o_last,
        "end or error result not last")

    `SLED_ASSERT_IMPLY(a_code_kind, i_clk, i_rst_n, !empty,
        (o_kind == KIND_ERR) == (o_error_code != ERR_NONE)
            && (o_kind == KIND_BYTE || o_out_byte == 8'd0),
        "error code or byte disagrees with kind")

    `SLED_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_kind) && $stable(o_out_byte) && $stable(o_last),
        "stalled result changed")

endmodule

bind string_literal_escape_decoder sled_checker u_sled_checker (.*);

@@ bench/string_literal_escape_decoder_checker.sv @@
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_checker
// watches both queue sides of the escape decoder, predicts every result
// from the accepted source bytes and compares each popped result with the
// oldest prediction
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_checker
    import sled_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_out_byte,
    input  logic [2:0] i_error_code,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_STRING,
        DEC_ESCAPE,
        DEC_HEX,
        DEC_DECIMAL,
        DEC_NEWLINE
    } t_decode_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] error_code;
        logic       last;
    } t_decoded;

    t_decode_mode mode;
    logic [7:0]   delimiter;
    logic [9:0]   escape_value;
    logic [1:0]   digit_count;
    logic         newline_was_cr;
    t_decoded     byte_results [0:1];
    int           byte_result_count;
    t_decoded     expected_results [$];
    int           mismatches = 0;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [7:0] value,
                        input logic [2:0] code);
        t_decoded r;
        r.kind       = kind;
        r.out_byte   = value;
        r.error_code = code;
        r.last       = 1'b0;
        byte_results[byte_result_count] = r;
        byte_result_count++;
    endtask

    task automatic abort_literal(input logic [2:0] code);
        emit(KIND_ERR, 8'h00, code);
        mode = DEC_IDLE;
    endtask

    // the delimiter test comes before every other one
    task automatic string_char(input logic [7:0] c);
        if (c == delimiter) begin
            emit(KIND_END, 8'h00, ERR_NONE);
            mode = DEC_IDLE;
        end else if (c == CH_NUL) begin
            abort_literal(ERR_EOF);
        end else if (c == CH_LF || c == CH_CR) begin
            abort_literal(ERR_NEWLINE);
        end else if (c == CH_BSLASH) begin
            mode = DEC_ESCAPE;
        end else begin
            emit(KIND_BYTE, c, ERR_NONE);
        end
    endtask

    task automatic escape_char(input logic [7:0] c);
        mode = DEC_STRING;
        case (c)
            "a": emit(KIND_BYTE, 8'd7, ERR_NONE);
            "b": emit(KIND_BYTE, 8'd8, ERR_NONE);
            "f": emit(KIND_BYTE, 8'd12, ERR_NONE);
            "n": emit(KIND_BYTE, 8'd10, ERR_NONE);
            "r": emit(KIND_BYTE, 8'd13, ERR_NONE);
            "t": emit(KIND_BYTE, 8'd9, ERR_NONE);
            "v": emit(KIND_BYTE, 8'd11, ERR_NONE);
            CH_BSLASH, CH_DQUOTE, CH_SQUOTE: emit(KIND_BYTE, c, ERR_NONE);
            "x": begin
                mode         = DEC_HEX;
                escape_value = '0;
                digit_count  = '0;
            end
            CH_LF, CH_CR: begin
                emit(KIND_BYTE, CH_LF, ERR_NONE);
                newline_was_cr = (c == CH_CR);
                mode           = DEC_NEWLINE;
            end
            CH_NUL: abort_literal(ERR_EOF);
            default: begin
                if (is_digit(c)) begin
                    mode         = DEC_DECIMAL;
                    escape_value = 10'(c - CH_ZERO);
                    digit_count  = 2'd1;
                end else begin
                    abort_literal(ERR_ESCAPE);
                end
            end
        endcase
    endtask

    task automatic decode_source_byte(input logic [7:0] data, input logic eoi);
        logic [7:0] c;
        int         nibble;
        int         sum;
        t_decoded   r;
        c = eoi ? CH_NUL : data;
        byte_result_count = 0;
        case (mode)
            DEC_STRING:  string_char(c);
            DEC_ESCAPE:  escape_char(c);
            DEC_HEX: begin
                nibble = hex_value(c);
                if (nibble < 0) begin
                    abort_literal(ERR_HEX);
                end else begin
                    escape_value = {2'b00, escape_value[3:0], nibble[3:0]};
                    digit_count  = digit_count + 2'd1;
                    if (digit_count >= 2'd2) begin
                        emit(KIND_BYTE, escape_value[7:0], ERR_NONE);
                        mode = DEC_STRING;
                    end
                end
            end
            DEC_DECIMAL: begin
                if (is_digit(c)) begin
                    sum          = escape_value * 10 + (c - CH_ZERO);
                    escape_value = sum[9:0];
                    digit_count  = digit_count + 2'd1;
                    if (digit_count >= 2'd3 || digit_count == 2'd0) begin
                        if (escape_value > 10'd255) begin
                            abort_literal(ERR_DEC);
                        end else begin
                            emit(KIND_BYTE, escape_value[7:0], ERR_NONE);
                            mode = DEC_STRING;
                        end
                    end
                end else begin
                    // short escape ends here, the byte itself is still decoded
                    emit(KIND_BYTE, escape_value[7:0], ERR_NONE);
                    mode = DEC_STRING;
                    string_char(c);
                end
            end
            DEC_NEWLINE: begin
                mode = DEC_STRING;
                if (!((newline_was_cr && c == CH_LF) || (!newline_was_cr && c == CH_CR)))
                    string_char(c);
            end
            default: begin
                mode = DEC_IDLE;
                if (c != CH_NUL) begin
                    delimiter = c;
                    mode      = DEC_STRING;
                end
            end
        endcase
        for (int i = 0; i < byte_result_count; i++) begin
            r      = byte_results[i];
            r.last = (i == byte_result_count - 1);
            expected_results.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            mode           = DEC_IDLE;
            delimiter      = '0;
            escape_value   = '0;
            digit_count    = '0;
            newline_was_cr = 1'b0;
            expected_results.delete();
        end else begin
            // predict first so a same-cycle result can find its expectation
            if (i_push && !i_full)
                decode_source_byte(i_data_byte, i_end_of_input);
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got kind %0d byte %0h error %0d last %0b",
                             $time, i_kind, i_out_byte, i_error_code, i_last);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_kind !== want.kind) begin
                        $display("%0t: kind mismatch, expected %0d, got %0d",
                                 $time, want.kind, i_kind);
                        mismatches++;
                    end
                    if (i_out_byte !== want.out_byte) begin
                        $display("%0t: out_byte mismatch, expected %0h, got %0h",
                                 $time, want.out_byte, i_out_byte);
                        mismatches++;
                    end
                    if (i_error_code !== want.error_code) begin
                        $display("%0t: error_code mismatch, expected %0d, got %0d",
                                 $time, want.error_code, i_error_code);
                        mismatches++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, want.last, i_last);
                        mismatches++;
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

@@ bench/string_literal_escape_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_tb
// drives source bytes into the escape decoder and pops its results; a short
// directed run covers the corner cases, then literals with random content and
// endings plus some raw noise run under three idling mixes, while the checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_tb;

    localparam int CYCLE_LIMIT = 200000;
    // random source transactions per idling phase, about 650 with the directed part
    localparam int PHASE_ITEMS = 208;
    // cycles allowed for results still in flight at the very end
    localparam int TAIL_CYCLES = 20;

    localparam logic [7:0]  CH_NUL    = 8'h00;
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_DQUOTE = 8'h22;
    localparam logic [7:0]  CH_SQUOTE = 8'h27;
    localparam logic [7:0]  CH_BSLASH = 8'h5C;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [55:0] CTRL_LETTERS = "abfnrtv";
    // escapes that stand for themselves
    localparam logic [23:0] SELF_ESCAPES = {CH_BSLASH, CH_DQUOTE, CH_SQUOTE};

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       push           = 1'b0;
    logic       full;
    logic [7:0] i_data_byte    = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       empty;
    logic       pop            = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic [2:0] o_error_code;
    logic       o_last;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent_items    = 0;
    int cycle_count   = 0;

    string_literal_escape_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_out_byte     (o_out_byte),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

    string_literal_escape_decoder_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_kind         (o_kind),
        .i_out_byte     (o_out_byte),
        .i_error_code   (o_error_code),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs on either side
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: pop is redrawn every falling edge, held low through reset
    always @(negedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one source transaction; entered and left at a falling edge, with random
    // idle cycles in front whose payload is junk
    task automatic send_source_byte(input logic [7:0] value, input logic eoi);
        bit accepted;
        accepted = 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            push           <= 1'b0;
            i_data_byte    <= 8'($urandom);
            i_end_of_input <= 1'($urandom);
            @(negedge i_clk);
        end
        push           <= 1'b1;
        i_data_byte    <= value;
        i_end_of_input <= eoi;
        while (!accepted) begin
            @(posedge i_clk);
            accepted = !full;
            @(negedge i_clk);
        end
        sent_items++;
    endtask

    // hold the source back until every predicted result has been popped
    task automatic drain_results();
        push <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nibble, input bit upper);
        if (nibble < 4'd10)
            return CH_ZERO + 8'(nibble);
        return (upper ? 8'h41 : 8'h61) + 8'(nibble) - 8'd10;
    endfunction

    initial begin
        logic [7:0] delim;
        logic [7:0] c;
        int         target;
        int         n_elems;
        int         val;
        int         ndig;
        int         ending;
        int         digit;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            // idling mixes: slow reader, then slow writer, then full rate
            case (phase)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct <= 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct <= 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase

            if (phase == 0) begin
                // nul and end of input in idle give nothing
                send_source_byte(CH_NUL, 1'b0);
                send_source_byte(8'hFF, 1'b1);
                // plain top byte, escaped delimiter, short decimal closed by
                // the delimiter, which gives two results in one transaction
                send_source_byte(CH_DQUOTE, 1'b0);
                send_source_byte(8'hFE, 1'b0);
                send_source_byte(CH_BSLASH, 1'b0);
                send_source_byte(CH_DQUOTE, 1'b0);
                send_source_byte(CH_BSLASH, 1'b0);
                send_source_byte("1", 1'b0);
                send_source_byte("2", 1'b0);
                send_source_byte(CH_DQUOTE, 1'b0);
                // 0xff as delimiter, cr-lf swallow, mixed-case hex, then end of
                // input carrying the delimiter value, which counts as nul
                send_source_byte(8'hFF, 1'b0);
                send_source_byte(CH_BSLASH, 1'b0);
                send_source_byte(CH_CR, 1'b0);
                send_source_byte(CH_LF, 1'b0);
                send_source_byte(8'h01, 1'b0);
                send_source_byte(CH_BSLASH, 1'b0);
                send_source_byte("x", 1'b0);
                send_source_byte("A", 1'b0);
                send_source_byte("f", 1'b0);
                send_source_byte(8'hFF, 1'b1);
                // nul straight after a backslash
                send_source_byte(CH_SQUOTE, 1'b0);
                send_source_byte(CH_BSLASH, 1'b0);
                send_source_byte(CH_NUL, 1'b0);
                // three-digit decimal above 255
                send_source_byte("q", 1'b0);
                send_source_byte(CH_BSLASH, 1'b0);
                send_source_byte("3", 1'b0);
                send_source_byte("0", 1'b0);
                send_source_byte("0", 1'b0);
                drain_results();
            end

            target = sent_items + PHASE_ITEMS;
            while (sent_items < target) begin
                if ($urandom_range(99) < 8) begin
                    // raw noise, now and then marked as end of input
                    send_source_byte(8'($urandom), $urandom_range(7) == 0);
                end else begin
                    // a literal: mostly quotes, sometimes any non-nul delimiter
                    case ($urandom_range(3))
                        0, 1: delim = CH_DQUOTE;
                        2:    delim = CH_SQUOTE;
                        default: delim = 8'($urandom_range(1, 255));
                    endcase
                    send_source_byte(delim, 1'b0);
                    n_elems = $urandom_range(0, 8);
                    for (int e = 0; e < n_elems; e++) begin
                        case ($urandom_range(11))
                            4: begin
                                send_source_byte(CH_BSLASH, 1'b0);
                                send_source_byte(CTRL_LETTERS[8*$urandom_range(6) +: 8], 1'b0);
                            end
                            5: begin
                                send_source_byte(CH_BSLASH, 1'b0);
                                send_source_byte(SELF_ESCAPES[8*$urandom_range(2) +: 8], 1'b0);
                            end
                            6: begin
                                // hex escape, one digit in eight replaced by junk
                                val = $urandom_range(255);
                                send_source_byte(CH_BSLASH, 1'b0);
                                send_source_byte("x", 1'b0);
                                c = hex_char(val[7:4], $urandom_range(1));
                                if ($urandom_range(7) == 0) c = 8'($urandom);
                                send_source_byte(c, 1'b0);
                                c = hex_char(val[3:0], $urandom_range(1));
                                if ($urandom_range(7) == 0) c = 8'($urandom);
                                send_source_byte(c, 1'b0);
                            end
                            7: begin
                                // decimal escape; short ones end on whatever follows
                                ndig = $urandom_range(1, 3);
                                val  = $urandom_range(ndig == 1 ? 9 : (ndig == 2 ? 99 : 399));
                                send_source_byte(CH_BSLASH, 1'b0);
                                for (int k = ndig - 1; k >= 0; k--) begin
                                    digit = (k == 2) ? val / 100 :
                                            (k == 1) ? (val / 10) % 10 : val % 10;
                                    send_source_byte(CH_ZERO + 8'(digit), 1'b0);
                                end
                            end
                            8: begin
                                // line continuation, then the partner newline,
                                // the same newline again, or nothing
                                c = $urandom_range(1) ? CH_CR : CH_LF;
                                send_source_byte(CH_BSLASH, 1'b0);
                                send_source_byte(c, 1'b0);
                                case ($urandom_range(3))
                                    0, 1: send_source_byte(c == CH_CR ? CH_LF : CH_CR, 1'b0);
                                    2:    send_source_byte(c, 1'b0);
                                    default: ;
                                endcase
                            end
                            9: begin
                                send_source_byte(CH_BSLASH, 1'b0);
                                send_source_byte(8'($urandom), 1'b0);
                            end
                            default: begin
                                // plain byte, kept clear of the bytes that end
                                // or escape the literal
                                c = 8'($urandom_range(1, 255));
                                if (c == delim || c == CH_LF || c == CH_CR || c == CH_BSLASH)
                                    c = "m";
                                send_source_byte(c, 1'b0);
                            end
                        endcase
                    end
                    ending = $urandom_range(19);
                    case (ending)
                        15: send_source_byte(8'($urandom), 1'b1);
                        16: send_source_byte(CH_NUL, 1'b0);
                        17: send_source_byte($urandom_range(1) ? CH_CR : CH_LF, 1'b0);
                        18: begin
                            send_source_byte(CH_BSLASH, 1'b0);
                            send_source_byte(8'($urandom), 1'b1);
                        end
                        19: ; // left open, the next delimiter becomes content
                        default: send_source_byte(delim, 1'b0);
                    endcase
                end
            end

            // at least one full stop of the source side mid-run
            if (phase == 0)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
